>>> hw/rtl/ddci_pkg.sv
// Shared types and constants for the copy/insert delta decoder.
`timescale 1ns / 1ps
package ddci_pkg;

  // Widest store address and copy length that the depth range allows.
  localparam int PTR_W = 24;
  localparam int LEN_W = 25;

  localparam int QDEPTH = 4;
  localparam int QPW = 2;

  localparam logic [7:0] SIG_BYTES [4] = '{8'h55, 8'h43, 8'h32, 8'h44};

  localparam logic [7:0] CMD_END    = 8'h00;
  localparam logic [7:0] CMD_COPY   = 8'h01;
  localparam logic [7:0] CMD_INSERT = 8'h02;

  localparam logic [3:0] HDR_BYTES = 4'd8;
  localparam logic [3:0] SIG_LEN   = 4'd4;

  typedef enum logic [1:0] {
    OP_SRC_WR  = 2'd0,
    OP_DELTA   = 2'd1,
    OP_READ    = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_BUSY = 2'd1,
    ST_OK   = 2'd2,
    ST_FAIL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_OPCODE,
    PH_COPY_OFF,
    PH_COPY_LEN,
    PH_INS_LEN,
    PH_INS_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_SRCW,
    K_TGTW,
    K_COPY,
    K_READ
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_COPY
  } bstate_t;

  // One queued job: the memory work and the result fields of one word.
  typedef struct packed {
    kind_t              kind;
    logic [PTR_W-1:0]   src;
    logic [PTR_W-1:0]   dst;
    logic [LEN_W-1:0]   len;
    logic [7:0]         data;
    logic               rd_ok;
    status_t            status;
    logic [16:0]        produced;
    logic [31:0]        declared;
  } job_t;

endpackage

>>> hw/rtl/ddci_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ddci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/ddci_queue.sv
// Short job queue between the parser and the executor.
`timescale 1ns / 1ps
module ddci_queue
  import ddci_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  job_t           q [QDEPTH];
  logic [QPW-1:0] wp;
  logic [QPW-1:0] rp;
  logic [QPW:0]   count;

  assign full       = (count == (QPW+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= push_job;
    end
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      count <= count + (QPW+1)'(push) - (QPW+1)'(pop);
    end
  end

endmodule

>>> hw/rtl/ddci_front.sv
// Front end: accepts words, parses the delta stream and queues jobs.
`timescale 1ns / 1ps
module ddci_front
  import ddci_pkg::*;
#(
  parameter int SRC_DEPTH = 65536,
  parameter int TGT_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [16:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_addr,
  input  logic [7:0]  in_data,
  input  logic        in_last,
  input  logic        q_full,
  output logic        push,
  output job_t        job
);

  localparam int WPW = $clog2(TGT_DEPTH + 1);

  logic [16:0]    src_len;
  phase_t         phase, phase_next;
  logic [1:0]     bcnt, bcnt_next;
  logic [31:0]    fsh, fsh_next;
  logic [31:0]    coff, coff_next;
  logic [31:0]    rem, rem_next;
  logic [WPW-1:0] wpos, wpos_next;
  logic [31:0]    htot, htot_next;
  logic [3:0]     dcnt, dcnt_next;
  status_t        outc, outc_next;

  logic [31:0]    gathered;
  logic           gdone;
  logic [32:0]    src_lim;
  logic [32:0]    wpos_end;
  logic           fail, finish, to_boundary;
  op_t            op;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign op       = op_t'(in_op);

  assign gathered = fsh | (32'(in_data) << {bcnt, 3'b000});
  assign gdone    = (bcnt == 2'd3);
  assign src_lim  = (33'(src_len) < 33'(SRC_DEPTH)) ? 33'(src_len) : 33'(SRC_DEPTH);
  assign wpos_end = 33'(wpos) + 33'(gathered);

  always_comb begin
    phase_next  = phase;
    bcnt_next   = bcnt;
    fsh_next    = fsh;
    coff_next   = coff;
    rem_next    = rem;
    wpos_next   = wpos;
    htot_next   = htot;
    dcnt_next   = dcnt;
    outc_next   = outc;
    fail        = 1'b0;
    finish      = 1'b0;
    to_boundary = 1'b0;
    job         = '0;
    job.kind    = K_NONE;

    case (op)
      OP_SRC_WR: begin
        if (32'(in_addr) < 32'(SRC_DEPTH)) begin
          job.kind = K_SRCW;
        end
        job.src  = PTR_W'(in_addr);
        job.data = in_data;
      end
      OP_READ: begin
        job.kind  = K_READ;
        job.dst   = PTR_W'(in_addr);
        job.rd_ok = (32'(in_addr) < 32'(wpos)) && (32'(in_addr) < 32'(TGT_DEPTH));
      end
      OP_RESTART: begin
        phase_next = PH_HEADER;
        bcnt_next  = '0;
        fsh_next   = '0;
        coff_next  = '0;
        rem_next   = '0;
        wpos_next  = '0;
        htot_next  = '0;
        dcnt_next  = '0;
        outc_next  = ST_IDLE;
      end
      default: begin
        if (outc != ST_OK && outc != ST_FAIL && phase != PH_DONE) begin
          outc_next = ST_BUSY;
          case (phase)
            PH_HEADER: begin
              if (dcnt < SIG_LEN) begin
                if (in_data != SIG_BYTES[dcnt[1:0]]) begin
                  fail = 1'b1;
                end
              end else begin
                htot_next = htot | (32'(in_data) << {dcnt[1:0], 3'b000});
              end
              if (!fail) begin
                dcnt_next = dcnt + 1'b1;
                if (in_last) begin
                  fail = 1'b1;
                end else if (dcnt_next >= HDR_BYTES) begin
                  if (33'(htot_next) > 33'(TGT_DEPTH)) begin
                    fail = 1'b1;
                  end else begin
                    to_boundary = 1'b1;
                  end
                end
              end
            end
            PH_OPCODE: begin
              bcnt_next = '0;
              fsh_next  = '0;
              if (in_data == CMD_END) begin
                finish = 1'b1;
              end else if (in_data == CMD_COPY) begin
                phase_next = PH_COPY_OFF;
                fail       = in_last;
              end else if (in_data == CMD_INSERT) begin
                phase_next = PH_INS_LEN;
                fail       = in_last;
              end else begin
                fail = 1'b1;
              end
            end
            PH_COPY_OFF: begin
              fsh_next  = gathered;
              bcnt_next = bcnt + 1'b1;
              if (gdone) begin
                coff_next  = gathered;
                fsh_next   = '0;
                bcnt_next  = '0;
                phase_next = PH_COPY_LEN;
              end
              fail = in_last;
            end
            PH_COPY_LEN: begin
              if (!gdone) begin
                fsh_next  = gathered;
                bcnt_next = bcnt + 1'b1;
                fail      = in_last;
              end else if (33'(coff) + 33'(gathered) > src_lim) begin
                fail = 1'b1;
              end else if (wpos_end > 33'(htot)) begin
                fail = 1'b1;
              end else begin
                if (gathered != '0) begin
                  job.kind = K_COPY;
                end
                job.src     = PTR_W'(coff);
                job.dst     = PTR_W'(wpos);
                job.len     = LEN_W'(gathered);
                wpos_next   = WPW'(wpos_end);
                to_boundary = 1'b1;
              end
            end
            PH_INS_LEN: begin
              if (!gdone) begin
                fsh_next  = gathered;
                bcnt_next = bcnt + 1'b1;
                fail      = in_last;
              end else if (wpos_end > 33'(htot)) begin
                fail = 1'b1;
              end else if (gathered == '0) begin
                to_boundary = 1'b1;
              end else begin
                rem_next   = gathered;
                phase_next = PH_INS_DATA;
                fail       = in_last;
              end
            end
            PH_INS_DATA: begin
              if (32'(wpos) < 32'(TGT_DEPTH)) begin
                job.kind = K_TGTW;
              end
              job.dst   = PTR_W'(wpos);
              job.data  = in_data;
              wpos_next = wpos + 1'b1;
              rem_next  = rem - 1'b1;
              if (rem_next == '0) begin
                to_boundary = 1'b1;
              end else begin
                fail = in_last;
              end
            end
            default: begin
              fail = 1'b1;
            end
          endcase

          if (to_boundary) begin
            phase_next = PH_OPCODE;
            bcnt_next  = '0;
            fsh_next   = '0;
            finish     = in_last;
          end
          if (fail) begin
            outc_next  = ST_FAIL;
            phase_next = PH_DONE;
          end else if (finish) begin
            outc_next  = ST_OK;
            phase_next = PH_DONE;
          end
        end
      end
    endcase

    job.status   = outc_next;
    job.produced = 17'(32'(wpos_next));
    job.declared = htot_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_len <= '0;
      phase   <= PH_HEADER;
      bcnt    <= '0;
      fsh     <= '0;
      coff    <= '0;
      rem     <= '0;
      wpos    <= '0;
      htot    <= '0;
      dcnt    <= '0;
      outc    <= ST_IDLE;
    end else begin
      if (cfg_wen) begin
        src_len <= cfg_wdata;
      end
      if (push) begin
        phase <= phase_next;
        bcnt  <= bcnt_next;
        fsh   <= fsh_next;
        coff  <= coff_next;
        rem   <= rem_next;
        wpos  <= wpos_next;
        htot  <= htot_next;
        dcnt  <= dcnt_next;
        outc  <= outc_next;
      end
    end
  end

endmodule

>>> hw/rtl/ddci_back.sv
// Back end: runs queued jobs against the stores and drives the result words.
`timescale 1ns / 1ps
module ddci_back
  import ddci_pkg::*;
#(
  parameter int SRC_DEPTH = 65536,
  parameter int TGT_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  job_t        head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_data
);

  localparam int SAW = $clog2(SRC_DEPTH);
  localparam int TAW = $clog2(TGT_DEPTH);

  bstate_t        state, state_next;
  logic [SAW-1:0] c_src;
  logic [TAW-1:0] c_dst;
  logic [LEN_W-1:0] c_cnt;
  logic           wv;
  logic [TAW-1:0] wa;

  logic           out_free;
  logic           load;
  logic           copy_start;
  logic           s_we, s_re, t_we, t_re;
  logic [SAW-1:0] s_waddr;
  logic [TAW-1:0] t_waddr;
  logic [7:0]     t_wdata;
  logic [7:0]     s_rdata, t_rdata;
  logic [7:0]     rd_byte;

  assign out_free = !out_valid || out_ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (head_valid && out_free) begin
          if (head.kind == K_READ) begin
            state_next = B_READ;
          end else if (head.kind == K_COPY) begin
            state_next = B_COPY;
          end
        end
      end
      B_READ: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      B_COPY: begin
        if (c_cnt == '0 && !wv) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    pop        = 1'b0;
    load       = 1'b0;
    copy_start = 1'b0;
    s_we       = 1'b0;
    s_re       = 1'b0;
    t_we       = 1'b0;
    t_re       = 1'b0;
    t_waddr    = head.dst[TAW-1:0];
    t_wdata    = head.data;
    case (state)
      B_IDLE: begin
        if (head_valid && out_free) begin
          case (head.kind)
            K_READ: begin
              t_re = head.rd_ok;
            end
            K_SRCW: begin
              s_we = 1'b1;
              load = 1'b1;
              pop  = 1'b1;
            end
            K_TGTW: begin
              t_we = 1'b1;
              load = 1'b1;
              pop  = 1'b1;
            end
            K_COPY: begin
              copy_start = 1'b1;
              load       = 1'b1;
              pop        = 1'b1;
            end
            default: begin
              load = 1'b1;
              pop  = 1'b1;
            end
          endcase
        end
      end
      B_READ: begin
        if (out_free) begin
          load = 1'b1;
          pop  = 1'b1;
        end
      end
      B_COPY: begin
        s_re    = (c_cnt != '0);
        t_we    = wv;
        t_waddr = wa;
        t_wdata = s_rdata;
      end
      default: begin
      end
    endcase
  end

  assign s_waddr = head.src[SAW-1:0];
  assign rd_byte = (state == B_READ && head.rd_ok) ? t_rdata : 8'h00;

  ddci_ram #(.WIDTH(8), .DEPTH(SRC_DEPTH)) u_src (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (head.data),
    .re    (s_re),
    .raddr (c_src),
    .rdata (s_rdata)
  );

  ddci_ram #(.WIDTH(8), .DEPTH(TGT_DEPTH)) u_tgt (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .re    (t_re),
    .raddr (head.dst[TAW-1:0]),
    .rdata (t_rdata)
  );

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= {5'b00000, head.declared, head.produced, rd_byte, head.status};
    end
    if (copy_start) begin
      c_src <= head.src[SAW-1:0];
      c_dst <= head.dst[TAW-1:0];
    end else if (s_re) begin
      c_src <= c_src + 1'b1;
      c_dst <= c_dst + 1'b1;
    end
    wa <= c_dst;
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      c_cnt     <= '0;
      wv        <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (copy_start) begin
        c_cnt <= head.len;
      end else if (s_re) begin
        c_cnt <= c_cnt - 1'b1;
      end
      // The source read issued this cycle lands in the target next cycle.
      wv <= s_re;
    end
  end

  a_copy_write_in_copy: assert property (@(posedge clk) disable iff (rst)
    wv |-> state == B_COPY)
    else $error("copy write outside copy state");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_read_holds_head: assert property (@(posedge clk) disable iff (rst)
    state == B_READ |-> head_valid && head.kind == K_READ)
    else $error("read state without read job");

  a_copy_no_load: assert property (@(posedge clk) disable iff (rst)
    state == B_COPY |-> !load && !pop)
    else $error("result loaded during copy");

endmodule

>>> hw/rtl/delta_decode_copy_insert.sv
// Top level of the copy/insert delta decoder.
//
//   channel  | direction | contents
//   s_axis   | in        | tuser: op[1:0]; tdata: addr[15:0], data[23:16]; tlast: last_byte
//   m_axis   | out       | tdata: status[1:0], read_data[9:2], produced_length[26:10],
//            |           |        declared_length[58:27], zero above
//   cfg      | in        | cfg_wen, cfg_wdata: source_length
//
// Every word gives one result word, in order. In the executor a READ passes
// through a read state, and a COPY of n bytes makes one source-store read per byte.
// A four-entry queue lets the parser run ahead while the executor copies.
// Reset is synchronous; the byte stores are not cleared.
// Stalls on m_axis back up through the queue to s_axis_tready.
`timescale 1ns / 1ps
module delta_decode_copy_insert
  import ddci_pkg::*;
#(
  parameter int SRC_DEPTH = 65536,
  parameter int TGT_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [16:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // addr[15:0], data[23:16]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // status, read_data, produced, declared
);

  logic push, q_full, pop, head_valid;
  job_t job, head;

  ddci_front #(.SRC_DEPTH(SRC_DEPTH), .TGT_DEPTH(TGT_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_addr   (s_axis_tdata[15:0]),
    .in_data   (s_axis_tdata[23:16]),
    .in_last   (s_axis_tlast),
    .q_full    (q_full),
    .push      (push),
    .job       (job)
  );

  ddci_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ddci_back #(.SRC_DEPTH(SRC_DEPTH), .TGT_DEPTH(TGT_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata)
  );

endmodule
